// ----- hdl/nstp_pkg.sv -----
// Package for the nested slot time profiler: operation codes, register
// indexes, state types and fixed arithmetic constants.
// No dependencies.
package nstp_pkg;

    typedef enum logic [3:0] {
        OP_ENTER     = 4'd0,
        OP_LEAVE     = 4'd1,
        OP_BEGIN     = 4'd2,
        OP_END       = 4'd3,
        OP_TAKE_PEAK = 4'd4,
        OP_CLR_TOTAL = 4'd5,
        OP_RD_LAST   = 4'd6,
        OP_RD_TOTAL  = 4'd7,
        OP_RD_LTOT   = 4'd8,
        OP_RD_BUFS   = 4'd9,
        OP_RD_FRAMES = 4'd10
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_SHARE_GO,
        ST_SHARE_WAIT,
        ST_EMIT,
        ST_READ
    } st_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL0,
        U_MUL1,
        U_MUL2,
        U_CMP,
        U_DIV
    } ust_t;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 1'b1;

    localparam int RATE_W   = 18;
    localparam int FRAMES_W = 16;
    localparam int STAMP_W  = 32;
    localparam int VALUE_W  = 48;
    localparam int DEPTH_W  = 6;
    localparam int PCT_W    = 16;
    localparam int B_W      = 26;  // 200 * sample rate
    localparam int C_W      = 36;  // frames * 1e6

    localparam logic [RATE_W-1:0]  RATE_RESET = 18'd44100;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX  = 6'd63;
    localparam logic [PCT_W-1:0]   PCT_SAT    = 16'hFFFF;
    localparam logic [B_W-1:0]     PCT_SCALE  = 26'd200;
    localparam logic [C_W-1:0]     USEC       = 36'd1000000;

endpackage

// ----- hdl/nested_slot_time_profiler.sv -----
// Nested slot time profiler top level: event decode, slot stack, per-slot
// timers and totals, and the end-of-buffer sequencer.
// Depends on nstp_pkg and nstp_pct_unit.
//
// Enter, leave, begin buffer, reset totals and ignored codes are handled in the
// idle state as they are accepted. Reads pass through a read state and wait for
// m_tready. Take peak streams NUM_SLOTS + 1 results, one per cycle while the sink
// is ready. End buffer sweeps all slots once and, when frames is nonzero, runs
// the shared percent unit once for the buffer and, on a new peak, once per slot;
// each run takes three multiply steps, a saturation compare and, unless the
// result saturates, sixteen divide steps. s_tready is low while a transaction
// is being worked on.
module nested_slot_time_profiler #(
    parameter int STACK_DEPTH = 8,
    parameter int NUM_SLOTS   = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // slot[4:0], now_us[36:5], frames[52:37], zero
    input  logic [3:0]  s_tuser,  // op[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // value[47:0]
    output logic [3:0]  m_tuser,  // slot_index[3:0]
    output logic        m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [nstp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nstp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int SW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int TW_T   = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    localparam int EW     = $clog2(NUM_SLOTS + 1);
    localparam int VW     = nstp_pkg::VALUE_W;

    nstp_pkg::st_t state_reg, state_next;
    nstp_pkg::op_t op;

    logic                          enable_reg;
    logic [nstp_pkg::RATE_W-1:0]   rate_reg;
    logic [SLOT_W-1:0]             stack_mem [STACK_DEPTH];
    logic [nstp_pkg::DEPTH_W-1:0]  nest_reg;
    logic [SLOT_W-1:0]             cur_reg;
    logic [31:0]                   stamp_reg, bstart_reg, ltot_reg, bufs_reg;
    logic [TIME_WIDTH-1:0]         running_reg [NUM_SLOTS];
    logic [TIME_WIDTH-1:0]         snap_reg [NUM_SLOTS];
    logic [VW-1:0]                 total_reg [NUM_SLOTS];
    logic [VW-1:0]                 fcnt_reg;
    logic [nstp_pkg::PCT_W-1:0]    peak_reg;
    logic [nstp_pkg::PCT_W-1:0]    share_reg [NUM_SLOTS];
    logic [nstp_pkg::FRAMES_W-1:0] frames_reg;
    logic [SLOT_W-1:0]             idx_reg;
    logic [EW-1:0]                 ecnt_reg;
    logic [VW-1:0]                 pend_reg;

    logic          out_valid_reg, out_last_reg;
    logic [VW-1:0] out_value_reg;
    logic [3:0]    out_idx_reg;

    logic                          acc, out_free, slot_ok, push_ok, pop_ok, idx_last;
    logic [4:0]                    in_slot;
    logic [31:0]                   in_now, elapsed;
    logic [nstp_pkg::FRAMES_W-1:0] in_frames;
    logic [SLOT_W-1:0]             slot_ix, rt_addr, tot_addr, pop_slot, sh_ix;
    logic [TIME_WIDTH-1:0]         rt_rd, rt_sum;
    logic [VW-1:0]                 tot_rd;
    logic [nstp_pkg::DEPTH_W-1:0]  nest_m1;
    logic [EW-1:0]                 ecnt_m1;
    logic                          pu_start, pu_done;
    logic [TW_T-1:0]               pu_t;
    logic [nstp_pkg::PCT_W-1:0]    pu_pct;

    assign acc       = s_tvalid && s_tready;
    assign op        = nstp_pkg::op_t'(s_tuser);
    assign in_slot   = s_tdata[4:0];
    assign in_now    = s_tdata[36:5];
    assign in_frames = s_tdata[52:37];
    assign out_free  = !out_valid_reg || m_tready;

    assign slot_ok  = ({2'b00, in_slot} < 7'(NUM_SLOTS));
    assign slot_ix  = SLOT_W'({1'b0, in_slot});
    assign elapsed  = in_now - stamp_reg;
    assign rt_addr  = (state_reg == nstp_pkg::ST_IDLE) ? cur_reg : idx_reg;
    assign rt_rd    = running_reg[rt_addr];
    assign rt_sum   = TIME_WIDTH'(TW_T'(rt_rd) + TW_T'(elapsed));
    assign tot_addr = (state_reg == nstp_pkg::ST_IDLE) ? slot_ix : idx_reg;
    assign tot_rd   = total_reg[tot_addr];
    assign push_ok  = ({1'b0, nest_reg} < 7'(STACK_DEPTH));
    assign nest_m1  = nest_reg - 6'd1;
    assign pop_ok   = ({1'b0, nest_m1} < 7'(STACK_DEPTH));
    assign pop_slot = pop_ok ? stack_mem[nest_m1[SW-1:0]] : '0;
    assign idx_last = (idx_reg == SLOT_W'(NUM_SLOTS - 1));
    assign ecnt_m1  = ecnt_reg - EW'(1);
    assign sh_ix    = SLOT_W'(ecnt_m1);

    assign pu_start = (state_reg == nstp_pkg::ST_PCT_GO) ||
                      (state_reg == nstp_pkg::ST_SHARE_GO);
    assign pu_t     = (state_reg == nstp_pkg::ST_PCT_GO) ? TW_T'(ltot_reg) : TW_T'(rt_rd);

    nstp_pct_unit #(.TW(TW_T)) u_pct (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (pu_start),
        .t_i      (pu_t),
        .frames_i (frames_reg),
        .rate_i   (rate_reg),
        .done_o   (pu_done),
        .pct_o    (pu_pct)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nstp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            nstp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (op) inside
                        nstp_pkg::OP_END: if (enable_reg) state_next = nstp_pkg::ST_ACC;
                        nstp_pkg::OP_TAKE_PEAK: state_next = nstp_pkg::ST_EMIT;
                        nstp_pkg::OP_RD_LAST, nstp_pkg::OP_RD_TOTAL, nstp_pkg::OP_RD_LTOT,
                        nstp_pkg::OP_RD_BUFS, nstp_pkg::OP_RD_FRAMES:
                            state_next = nstp_pkg::ST_READ;
                        default: ;
                    endcase
                end
            end
            nstp_pkg::ST_ACC: begin
                if (idx_last) begin
                    state_next = (frames_reg != '0) ? nstp_pkg::ST_PCT_GO : nstp_pkg::ST_IDLE;
                end
            end
            nstp_pkg::ST_PCT_GO: state_next = nstp_pkg::ST_PCT_WAIT;
            nstp_pkg::ST_PCT_WAIT: begin
                if (pu_done) begin
                    state_next = (pu_pct > peak_reg) ? nstp_pkg::ST_SHARE_GO
                                                     : nstp_pkg::ST_IDLE;
                end
            end
            nstp_pkg::ST_SHARE_GO: state_next = nstp_pkg::ST_SHARE_WAIT;
            nstp_pkg::ST_SHARE_WAIT: begin
                if (pu_done) begin
                    state_next = idx_last ? nstp_pkg::ST_IDLE : nstp_pkg::ST_SHARE_GO;
                end
            end
            nstp_pkg::ST_EMIT: begin
                if (out_free && (ecnt_reg == EW'(NUM_SLOTS))) state_next = nstp_pkg::ST_IDLE;
            end
            nstp_pkg::ST_READ: if (out_free) state_next = nstp_pkg::ST_IDLE;
            default: state_next = nstp_pkg::ST_IDLE;
        endcase
    end

    // Return stack: entries are only read after being pushed.
    always_ff @(posedge aclk) begin
        if (acc && (op == nstp_pkg::OP_ENTER) && slot_ok && push_ok) begin
            stack_mem[nest_reg[SW-1:0]] <= cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            rate_reg      <= nstp_pkg::RATE_RESET;
            nest_reg      <= '0;
            cur_reg       <= '0;
            stamp_reg     <= '0;
            bstart_reg    <= '0;
            ltot_reg      <= '0;
            bufs_reg      <= '0;
            fcnt_reg      <= '0;
            peak_reg      <= '0;
            idx_reg       <= '0;
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                running_reg[i] <= '0;
                snap_reg[i]    <= '0;
                total_reg[i]   <= '0;
                share_reg[i]   <= '0;
            end
        end else begin
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    nstp_pkg::CFG_ENABLE: begin
                        enable_reg <= cfg_data[0];
                        nest_reg   <= '0;
                        cur_reg    <= '0;
                    end
                    nstp_pkg::CFG_RATE: rate_reg <= cfg_data[nstp_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                nstp_pkg::ST_IDLE: begin
                    idx_reg  <= '0;
                    ecnt_reg <= '0;
                    if (acc) begin
                        case (op) inside
                            nstp_pkg::OP_ENTER: begin
                                if (slot_ok) begin
                                    if (nest_reg != nstp_pkg::DEPTH_MAX) nest_reg <= nest_reg + 6'd1;
                                    running_reg[cur_reg] <= rt_sum;
                                    stamp_reg <= in_now;
                                    cur_reg   <= slot_ix;
                                end
                            end
                            nstp_pkg::OP_LEAVE: begin
                                if (nest_reg != '0) begin
                                    nest_reg <= nest_m1;
                                    running_reg[cur_reg] <= rt_sum;
                                    stamp_reg <= in_now;
                                    cur_reg   <= pop_slot;
                                end
                            end
                            nstp_pkg::OP_BEGIN: begin
                                if (enable_reg) begin
                                    for (int i = 0; i < NUM_SLOTS; i++) running_reg[i] <= '0;
                                    nest_reg   <= '0;
                                    cur_reg    <= '0;
                                    stamp_reg  <= in_now;
                                    bstart_reg <= in_now;
                                end
                            end
                            nstp_pkg::OP_END: begin
                                if (enable_reg) begin
                                    running_reg[cur_reg] <= rt_sum;
                                    stamp_reg  <= in_now;
                                    ltot_reg   <= in_now - bstart_reg;
                                    bufs_reg   <= bufs_reg + 32'd1;
                                    fcnt_reg   <= fcnt_reg + VW'(in_frames);
                                    frames_reg <= in_frames;
                                end
                            end
                            nstp_pkg::OP_CLR_TOTAL: begin
                                for (int i = 0; i < NUM_SLOTS; i++) begin
                                    total_reg[i] <= '0;
                                    share_reg[i] <= '0;
                                end
                                bufs_reg <= '0;
                                fcnt_reg <= '0;
                                peak_reg <= '0;
                            end
                            nstp_pkg::OP_RD_LAST:
                                pend_reg <= slot_ok ? VW'(snap_reg[slot_ix]) : '0;
                            nstp_pkg::OP_RD_TOTAL:  pend_reg <= slot_ok ? tot_rd : '0;
                            nstp_pkg::OP_RD_LTOT:   pend_reg <= VW'(ltot_reg);
                            nstp_pkg::OP_RD_BUFS:   pend_reg <= VW'(bufs_reg);
                            nstp_pkg::OP_RD_FRAMES: pend_reg <= fcnt_reg;
                            default: ;
                        endcase
                    end
                end
                nstp_pkg::ST_ACC: begin
                    snap_reg[idx_reg]  <= rt_rd;
                    total_reg[idx_reg] <= tot_rd + VW'(rt_rd);
                    idx_reg <= idx_last ? '0 : idx_reg + SLOT_W'(1);
                end
                nstp_pkg::ST_PCT_WAIT: begin
                    if (pu_done && (pu_pct > peak_reg)) peak_reg <= pu_pct;
                end
                nstp_pkg::ST_SHARE_WAIT: begin
                    if (pu_done) begin
                        share_reg[idx_reg] <= pu_pct;
                        idx_reg <= idx_last ? '0 : idx_reg + SLOT_W'(1);
                    end
                end
                nstp_pkg::ST_EMIT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        if (ecnt_reg == '0) begin
                            out_value_reg <= VW'(peak_reg);
                            out_idx_reg   <= 4'd0;
                        end else begin
                            out_value_reg <= VW'(share_reg[sh_ix]);
                            out_idx_reg   <= 4'(ecnt_m1);
                        end
                        out_last_reg <= (ecnt_reg == EW'(NUM_SLOTS));
                        ecnt_reg     <= ecnt_reg + EW'(1);
                        if (ecnt_reg == EW'(NUM_SLOTS)) begin
                            peak_reg <= '0;
                            for (int i = 0; i < NUM_SLOTS; i++) share_reg[i] <= '0;
                        end
                    end
                end
                nstp_pkg::ST_READ: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= pend_reg;
                        out_idx_reg   <= 4'd0;
                        out_last_reg  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- hdl/nstp_pct_unit.sv -----
// Shared load percent unit: round(t * 100 * rate / (frames * 1e6)),
// saturated to 16 bits, by split multiply and restoring division.
// Depends on nstp_pkg.
module nstp_pct_unit #(
    parameter int TW = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start_i,
    input  logic [TW-1:0]                 t_i,
    input  logic [nstp_pkg::FRAMES_W-1:0] frames_i,
    input  logic [nstp_pkg::RATE_W-1:0]   rate_i,
    output logic                          done_o,
    output logic [nstp_pkg::PCT_W-1:0]    pct_o
);

    localparam int NW   = TW + 27;
    localparam int LP_W = 24 + nstp_pkg::B_W;
    localparam int HP_W = TW - 24 + nstp_pkg::B_W;

    nstp_pkg::ust_t state_reg, state_next;

    logic [TW-1:0]                 t_reg;
    logic [nstp_pkg::FRAMES_W-1:0] f_reg;
    logic [nstp_pkg::RATE_W-1:0]   r_reg;
    logic [nstp_pkg::B_W-1:0]      b_reg;
    logic [nstp_pkg::C_W-1:0]      c_reg;
    logic [NW-1:0]                 num_reg, dsh_reg, dfull;
    logic [nstp_pkg::PCT_W-1:0]    q_reg, pct_reg;
    logic [3:0]                    k_reg;
    logic                          done_reg;
    logic                          ge;

    // Divisor is twice frames * 1e6, the rounding term is added to the product.
    assign dfull = NW'({c_reg, 1'b0});
    assign ge    = (num_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nstp_pkg::U_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nstp_pkg::U_IDLE: if (start_i) state_next = nstp_pkg::U_MUL0;
            nstp_pkg::U_MUL0: state_next = nstp_pkg::U_MUL1;
            nstp_pkg::U_MUL1: state_next = nstp_pkg::U_MUL2;
            nstp_pkg::U_MUL2: state_next = nstp_pkg::U_CMP;
            nstp_pkg::U_CMP: begin
                if (num_reg >= (dfull << 16)) state_next = nstp_pkg::U_IDLE;
                else state_next = nstp_pkg::U_DIV;
            end
            nstp_pkg::U_DIV: if (k_reg == 4'd0) state_next = nstp_pkg::U_IDLE;
            default: state_next = nstp_pkg::U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                nstp_pkg::U_CMP: if (num_reg >= (dfull << 16)) done_reg <= 1'b1;
                nstp_pkg::U_DIV: if (k_reg == 4'd0) done_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            nstp_pkg::U_IDLE: begin
                t_reg <= t_i;
                f_reg <= frames_i;
                r_reg <= rate_i;
            end
            nstp_pkg::U_MUL0: begin
                b_reg <= nstp_pkg::B_W'(r_reg) * nstp_pkg::PCT_SCALE;
                c_reg <= nstp_pkg::C_W'(f_reg) * nstp_pkg::USEC;
            end
            nstp_pkg::U_MUL1: begin
                num_reg <= NW'(LP_W'(t_reg[23:0]) * LP_W'(b_reg)) + NW'(c_reg);
            end
            nstp_pkg::U_MUL2: begin
                num_reg <= num_reg + (NW'(HP_W'(t_reg[TW-1:24]) * HP_W'(b_reg)) << 24);
            end
            nstp_pkg::U_CMP: begin
                pct_reg <= nstp_pkg::PCT_SAT;
                dsh_reg <= dfull << 15;
                k_reg   <= 4'd15;
                q_reg   <= '0;
            end
            nstp_pkg::U_DIV: begin
                if (ge) num_reg <= num_reg - dsh_reg;
                q_reg   <= {q_reg[nstp_pkg::PCT_W-2:0], ge};
                pct_reg <= {q_reg[nstp_pkg::PCT_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                k_reg   <= k_reg - 4'd1;
            end
            default: ;
        endcase
    end

    assign done_o = done_reg;
    assign pct_o  = pct_reg;

endmodule

// ----- hdl/nstp_checker.sv -----
// Port-level checker for the nested slot time profiler and its bind.
// Depends on nstp_pkg and nested_slot_time_profiler.
module nstp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [3:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    logic in_acc, rd_op;

    assign in_acc = s_tvalid && s_tready;
    assign rd_op  = (s_tuser == nstp_pkg::OP_TAKE_PEAK) || (s_tuser == nstp_pkg::OP_RD_LAST) ||
                    (s_tuser == nstp_pkg::OP_RD_TOTAL) || (s_tuser == nstp_pkg::OP_RD_LTOT) ||
                    (s_tuser == nstp_pkg::OP_RD_BUFS) || (s_tuser == nstp_pkg::OP_RD_FRAMES);

    // Result register comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Only a result marked last may be wider than a percent.
    a_pct_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[47:16] == 32'd0))
        else $error("non-final result wider than 16 bits");

    // An op that produces results keeps the input side busy next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && rd_op |=> !s_tready)
        else $error("input accepted while results pending");

endmodule

bind nested_slot_time_profiler nstp_checker u_nstp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- sim/tb_nested_slot_time_profiler.sv -----
// Self-checking testbench for the nested slot time profiler: a scoreboard class
// predicts every result, and plain tasks drive the stream and config ports.
// Depends on nstp_pkg and the nested_slot_time_profiler RTL.
module tb_nested_slot_time_profiler;

    typedef struct packed {
        logic [47:0] value;
        logic [3:0]  slot_index;
        logic        last;
    } profile_result_t;

    class profile_scoreboard_t;
        logic              enable;
        logic [17:0]       rate;
        logic [3:0]        ret_stack [8];
        logic [5:0]        depth;
        logic [3:0]        cur_slot;
        logic [31:0]       last_stamp;
        logic [31:0]       buf_start;
        logic [31:0]       run_time [16];
        logic [31:0]       snap_time [16];
        logic [47:0]       tot_time [16];
        logic [31:0]       last_total;
        logic [31:0]       buf_count;
        logic [47:0]       frame_count;
        logic [15:0]       peak_pct;
        logic [15:0]       peak_share [16];
        profile_result_t   expected_q [$];
        int                mismatches;
        int                checked;

        function new();
            enable = 1'b0;
            rate = nstp_pkg::RATE_RESET;
            depth = '0;
            cur_slot = '0;
            last_stamp = '0;
            buf_start = '0;
            last_total = '0;
            buf_count = '0;
            frame_count = '0;
            peak_pct = '0;
            mismatches = 0;
            checked = 0;
            for (int i = 0; i < 16; i++) begin
                run_time[i] = '0;
                snap_time[i] = '0;
                tot_time[i] = '0;
                peak_share[i] = '0;
            end
            for (int i = 0; i < 8; i++) ret_stack[i] = '0;
        endfunction

        function void write_reg(logic [nstp_pkg::CFG_IDX_W-1:0] idx, logic [17:0] data);
            if (idx == nstp_pkg::CFG_ENABLE) begin
                enable = data[0];
                depth = '0;
                cur_slot = '0;
            end else begin
                rate = data;
            end
        endfunction

        // Round-half-up of t*100*rate / (frames*1e6), saturated to 16 bits.
        function logic [15:0] load_pct(logic [31:0] t, logic [15:0] frames);
            longint unsigned b, d, c, q1, r1, q;
            b = 200 * longint'(rate);
            c = longint'(frames) * 1000000;
            d = 2 * c;
            if (d == 0) return '0;
            q1 = t / d;
            r1 = t % d;
            if (q1 >= 65536 && b != 0) return nstp_pkg::PCT_SAT;
            q = q1 * b + (r1 * b + c) / d;
            return (q > 65535) ? nstp_pkg::PCT_SAT : q[15:0];
        endfunction

        function void switch_to(logic [3:0] s, logic [31:0] now);
            run_time[cur_slot] = run_time[cur_slot] + (now - last_stamp);
            last_stamp = now;
            cur_slot = s;
        endfunction

        function void push_result(logic [47:0] v, logic [3:0] idx, logic fin);
            profile_result_t r;
            r.value = v;
            r.slot_index = idx;
            r.last = fin;
            expected_q.push_back(r);
        endfunction

        function void note_input(logic [3:0] op, logic [4:0] slot, logic [31:0] now,
                                 logic [15:0] frames);
            logic [15:0] pct;
            case (op)
                nstp_pkg::OP_ENTER: begin
                    if (slot < 16) begin
                        if (depth < 8) ret_stack[depth[2:0]] = cur_slot;
                        if (depth < nstp_pkg::DEPTH_MAX) depth = depth + 6'd1;
                        switch_to(slot[3:0], now);
                    end
                end
                nstp_pkg::OP_LEAVE: begin
                    if (depth != 0) begin
                        depth = depth - 6'd1;
                        switch_to((depth < 8) ? ret_stack[depth[2:0]] : 4'd0, now);
                    end
                end
                nstp_pkg::OP_BEGIN: begin
                    if (enable) begin
                        for (int i = 0; i < 16; i++) run_time[i] = '0;
                        depth = '0;
                        cur_slot = '0;
                        last_stamp = now;
                        buf_start = now;
                    end
                end
                nstp_pkg::OP_END: begin
                    if (enable) begin
                        switch_to(cur_slot, now);
                        last_total = now - buf_start;
                        for (int i = 0; i < 16; i++) begin
                            snap_time[i] = run_time[i];
                            tot_time[i] = tot_time[i] + 48'(run_time[i]);
                        end
                        buf_count = buf_count + 32'd1;
                        frame_count = frame_count + 48'(frames);
                        if (frames != 0) begin
                            pct = load_pct(last_total, frames);
                            if (pct > peak_pct) begin
                                peak_pct = pct;
                                for (int i = 0; i < 16; i++)
                                    peak_share[i] = load_pct(run_time[i], frames);
                            end
                        end
                    end
                end
                nstp_pkg::OP_TAKE_PEAK: begin
                    push_result(48'(peak_pct), 4'd0, 1'b0);
                    for (int i = 0; i < 16; i++) begin
                        push_result(48'(peak_share[i]), 4'(i), (i == 15));
                        peak_share[i] = '0;
                    end
                    peak_pct = '0;
                end
                nstp_pkg::OP_CLR_TOTAL: begin
                    for (int i = 0; i < 16; i++) begin
                        tot_time[i] = '0;
                        peak_share[i] = '0;
                    end
                    buf_count = '0;
                    frame_count = '0;
                    peak_pct = '0;
                end
                nstp_pkg::OP_RD_LAST:
                    push_result((slot < 16) ? 48'(snap_time[slot[3:0]]) : 48'd0, 4'd0, 1'b1);
                nstp_pkg::OP_RD_TOTAL:
                    push_result((slot < 16) ? tot_time[slot[3:0]] : 48'd0, 4'd0, 1'b1);
                nstp_pkg::OP_RD_LTOT:   push_result(48'(last_total), 4'd0, 1'b1);
                nstp_pkg::OP_RD_BUFS:   push_result(48'(buf_count), 4'd0, 1'b1);
                nstp_pkg::OP_RD_FRAMES: push_result(frame_count, 4'd0, 1'b1);
                default: ;
            endcase
        endfunction

        function void check_result(logic [47:0] value, logic [3:0] idx, logic fin);
            profile_result_t e;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result value=%0h slot=%0d last=%0b",
                             value, idx, fin);
                return;
            end
            e = expected_q.pop_front();
            if (e.value !== value || e.slot_index !== idx || e.last !== fin) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d expected %0h/%0d/%0b got %0h/%0d/%0b",
                             checked, e.value, e.slot_index, e.last, value, idx, fin);
            end
        endfunction
    endclass

    localparam logic [3:0] OP_UNUSED_LO = 4'(nstp_pkg::OP_RD_FRAMES + 1);
    localparam logic [3:0] OP_UNUSED_HI = '1;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic                            cfg_wr_en;
    logic [nstp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [nstp_pkg::CFG_DATA_W-1:0] cfg_data;

    profile_scoreboard_t sb;
    int          burst_left;
    int          items_sent;
    int          idle_cycles = 0;
    int          stall_mode = 0;
    int          cycle_count = 0;
    logic [31:0] clock_us;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 500;

    nested_slot_time_profiler u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: checks each transaction and stalls on its own pattern.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 2);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= (cycle_count % 7 > 2);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding",
                     sb.expected_q.size());
            $display("FAIL nested_slot_time_profiler");
            $finish;
        end
    end

    task automatic send_item(logic [3:0] op, logic [4:0] slot, logic [31:0] now,
                             logic [15:0] frames);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, frames, now, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, slot, now, frames);
        items_sent++;
    endtask

    task automatic advance_send(logic [3:0] op, logic [4:0] slot, logic [15:0] frames);
        clock_us = clock_us + $urandom_range(0, 3000);
        send_item(op, slot, clock_us, frames);
    endtask

    // Registers change only once the block has gone quiet, end buffer included.
    task automatic write_reg(logic [nstp_pkg::CFG_IDX_W-1:0] idx, logic [17:0] data);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic random_frames(output logic [15:0] f);
        case ($urandom_range(0, 9))
            0:       f = 16'd0;
            1:       f = 16'd1;
            2:       f = 16'hFFFF;
            3:       f = 16'($urandom);
            default: f = 16'($urandom_range(32, 1024));
        endcase
    endtask

    // Nest past the stack and the depth counter, then unwind.
    task automatic deep_nest();
        for (int i = 0; i < 66; i++)
            advance_send(nstp_pkg::OP_ENTER, 5'($urandom_range(0, 15)), 16'd0);
        for (int i = 0; i < 66; i++)
            advance_send(nstp_pkg::OP_LEAVE, 5'd0, 16'd0);
    endtask

    // One buffer with random nesting inside, then up to three reads and at times a take peak or a clear of the totals.
    task automatic random_buffer();
        logic [15:0] f;
        logic [4:0]  s;
        int          n;
        if ($urandom_range(0, 7) == 0) clock_us = $urandom;
        advance_send(nstp_pkg::OP_BEGIN, 5'($urandom), 16'($urandom));
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            s = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(0, 15));
            if ($urandom_range(0, 2) == 0)
                advance_send(nstp_pkg::OP_LEAVE, 5'($urandom), 16'($urandom));
            else
                advance_send(nstp_pkg::OP_ENTER, s, 16'($urandom));
        end
        random_frames(f);
        advance_send(nstp_pkg::OP_END, 5'($urandom), f);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            advance_send(4'($urandom_range(nstp_pkg::OP_RD_LAST, nstp_pkg::OP_RD_FRAMES)),
                         5'($urandom), 16'($urandom));
        if ($urandom_range(0, 4) == 0)
            advance_send(nstp_pkg::OP_TAKE_PEAK, 5'($urandom), 16'($urandom));
        if ($urandom_range(0, 19) == 0)
            advance_send(nstp_pkg::OP_CLR_TOTAL, 5'($urandom), 16'($urandom));
    endtask

    task automatic random_phase(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            case ($urandom_range(0, 19))
                0, 1: send_item(4'($urandom), 5'($urandom), $urandom, 16'($urandom));
                2: begin
                    // Nest a little past the return stack, then unwind.
                    for (int i = 0; i < 10; i++)
                        advance_send(nstp_pkg::OP_ENTER, 5'($urandom_range(0, 15)), 16'd0);
                    for (int i = 0; i < 10; i++)
                        advance_send(nstp_pkg::OP_LEAVE, 5'd0, 16'd0);
                end
                default: random_buffer();
            endcase
        end
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        items_sent = 0;
        clock_us = 32'd1000;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: disabled buffer events, nesting corner cases, reads, peaks, ignored codes, a clear of the totals.
        send_item(nstp_pkg::OP_BEGIN, 5'd0, 32'd100, 16'd0);
        send_item(nstp_pkg::OP_END, 5'd0, 32'd900, 16'd64);
        send_item(nstp_pkg::OP_RD_BUFS, 5'd0, 32'd0, 16'd0);
        write_reg(nstp_pkg::CFG_ENABLE, 18'd1);
        send_item(nstp_pkg::OP_BEGIN, 5'd0, 32'd1000, 16'd0);
        send_item(nstp_pkg::OP_ENTER, 5'd3, 32'd1500, 16'd0);
        send_item(nstp_pkg::OP_ENTER, 5'd31, 32'd1700, 16'd0);
        send_item(nstp_pkg::OP_ENTER, 5'd15, 32'd2000, 16'd0);
        send_item(nstp_pkg::OP_LEAVE, 5'd0, 32'd2600, 16'd0);
        send_item(nstp_pkg::OP_LEAVE, 5'd0, 32'd3100, 16'd0);
        send_item(nstp_pkg::OP_LEAVE, 5'd0, 32'd3300, 16'd0);
        send_item(nstp_pkg::OP_END, 5'd0, 32'd12000, 16'd0);
        send_item(nstp_pkg::OP_RD_LAST, 5'd3, 32'd0, 16'd0);
        send_item(nstp_pkg::OP_RD_LAST, 5'd31, 32'd0, 16'd0);
        send_item(nstp_pkg::OP_RD_TOTAL, 5'd15, 32'd0, 16'd0);
        send_item(nstp_pkg::OP_BEGIN, 5'd0, 32'hFFFF_FF00, 16'd0);
        send_item(nstp_pkg::OP_ENTER, 5'd7, 32'hFFFF_FFFF, 16'd0);
        send_item(nstp_pkg::OP_END, 5'd0, 32'h0010_0000, 16'd1);
        send_item(nstp_pkg::OP_RD_LTOT, 5'd0, 32'd0, 16'd0);
        send_item(nstp_pkg::OP_TAKE_PEAK, 5'd0, 32'd0, 16'd0);
        send_item(nstp_pkg::OP_BEGIN, 5'd0, 32'd0, 16'd0);
        send_item(nstp_pkg::OP_END, 5'd0, 32'd1000, 16'hFFFF);
        send_item(nstp_pkg::OP_RD_FRAMES, 5'd0, 32'd0, 16'd0);
        send_item(OP_UNUSED_LO, 5'd31, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_UNUSED_HI, 5'd0, 32'd0, 16'd0);
        send_item(nstp_pkg::OP_CLR_TOTAL, 5'd0, 32'd0, 16'd0);
        send_item(nstp_pkg::OP_TAKE_PEAK, 5'd0, 32'd0, 16'd0);
        deep_nest();

        random_phase(70);
        write_reg(nstp_pkg::CFG_RATE, 18'd192000);
        random_phase(50);
        write_reg(nstp_pkg::CFG_RATE, 18'd1);
        random_phase(40);
        write_reg(nstp_pkg::CFG_RATE, 18'd0);
        random_phase(30);
        write_reg(nstp_pkg::CFG_ENABLE, 18'd0);
        random_phase(25);
        write_reg(nstp_pkg::CFG_ENABLE, 18'd1);
        write_reg(nstp_pkg::CFG_RATE, 18'($urandom_range(1, 192000)));
        random_phase(50);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Ran %0d events: directed corners, a deep nest and random buffers,", items_sent);
        $display("across several enable and sample rate settings; %0d results checked.",
                 sb.checked);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("PASS nested_slot_time_profiler");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("FAIL nested_slot_time_profiler");
        end
        $finish;
    end
endmodule
